[hw/rtl/rrts_pkg.sv]
// Shared types, request codes and sizes of the round-robin thread scheduler.
`default_nettype none

package rrts_pkg;

  localparam int NumThreadsDef = 6;
  localparam int NumSemsDef    = 8;
  localparam int TickWrapDef   = 100;

  localparam int ReqW       = 3;
  localparam int SemIdxW    = 3;
  localparam int SemW       = 16;
  localparam int SleepW     = 16;
  localparam int PeriodW    = 7;
  localparam int ThreadOutW = 3;
  localparam int ApbDataW   = 32;
  localparam int ApbAddrW   = 3;

  localparam logic [ReqW-1:0] REQ_TICK   = 3'd0;
  localparam logic [ReqW-1:0] REQ_SLICE  = 3'd1;
  localparam logic [ReqW-1:0] REQ_SLEEP  = 3'd2;
  localparam logic [ReqW-1:0] REQ_WAIT   = 3'd3;
  localparam logic [ReqW-1:0] REQ_SIGNAL = 3'd4;
  localparam logic [ReqW-1:0] REQ_INIT   = 3'd5;

  localparam logic REG_EVENT0 = 1'b0;
  localparam logic REG_EVENT1 = 1'b1;

  localparam logic signed [SemW-1:0] SemMin = 16'sh8000;
  localparam logic signed [SemW-1:0] SemMax = 16'sh7fff;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic srch_step;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_tick;
    logic need_srch;
    logic step_last;
    logic srch_hit;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/rrts_ctrl.sv]
// Controller state machine of the thread scheduler.
`default_nettype none

module rrts_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  start_i,
  input  wire rrts_pkg::sts_t  sts_i,
  output rrts_pkg::cmd_t       cmd_o,
  output logic                 busy_o,
  output logic                 done_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.is_tick) begin
          state_d = ST_DIV;
        end else if (sts_i.need_srch) begin
          state_d = ST_SRCH;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SRCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.srch_hit || sts_i.step_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_DONE);

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE |=> state_q == ST_IDLE)
    else $error("result strobe lasted more than one cycle");

  a_start_execs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE && start_i |=> state_q == ST_EXEC)
    else $error("accepted item did not start execution");

  a_short_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EXEC && !sts_i.is_tick && !sts_i.need_srch |=> state_q == ST_DONE)
    else $error("request without search did not finish");

endmodule

`default_nettype wire

[hw/rtl/rrts_dp.sv]
// Datapath of the thread scheduler: thread state, semaphores, tick divider, search.
`default_nettype none

module rrts_dp #(
  parameter int NUM_THREADS = rrts_pkg::NumThreadsDef,
  parameter int NUM_SEMS    = rrts_pkg::NumSemsDef,
  parameter int TICK_WRAP   = rrts_pkg::TickWrapDef
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire rrts_pkg::cmd_t                    cmd_i,
  output rrts_pkg::sts_t                         sts_o,
  input  wire [rrts_pkg::ReqW-1:0]               req_type_i,
  input  wire [rrts_pkg::SemIdxW-1:0]            sem_index_i,
  input  wire signed [rrts_pkg::SemW-1:0]        init_value_i,
  input  wire [rrts_pkg::SleepW-1:0]             sleep_ms_i,
  input  wire [rrts_pkg::PeriodW-1:0]            event0_period_i,
  input  wire [rrts_pkg::PeriodW-1:0]            event1_period_i,
  output logic [rrts_pkg::ThreadOutW-1:0]        running_thread_o,
  output logic                                   fire_event0_o,
  output logic                                   fire_event1_o,
  output logic                                   idle_flag_o,
  output logic                                   no_waiter_flag_o,
  output logic signed [rrts_pkg::SemW-1:0]       sem_count_o
);

  localparam int ThrW    = $clog2(NUM_THREADS);
  localparam int SemAW   = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int TickW   = $clog2(TICK_WRAP);
  localparam int StepMax = (NUM_THREADS > TickW) ? NUM_THREADS : TickW;
  localparam int StepW   = $clog2(StepMax + 1);
  localparam int PerW    = rrts_pkg::PeriodW;
  localparam int SemW    = rrts_pkg::SemW;

  localparam logic [ThrW-1:0]  LastThr  = ThrW'(NUM_THREADS - 1);
  localparam logic [TickW-1:0] LastTick = TickW'(TICK_WRAP - 1);

  // One restoring-division step on the remainder only.
  function automatic logic [PerW-1:0] rem_step(input logic [PerW-1:0] rem,
                                               input logic            din,
                                               input logic [PerW-1:0] per);
    logic [PerW:0] t;
    logic [PerW:0] s;
    t = {rem, din};
    s = t - {1'b0, per};
    return (t >= {1'b0, per}) ? s[PerW-1:0] : t[PerW-1:0];
  endfunction

  // Latched request.
  logic [rrts_pkg::ReqW-1:0]    req_q;
  logic [rrts_pkg::SemIdxW-1:0] idx_q;
  logic signed [SemW-1:0]       init_q;
  logic [rrts_pkg::SleepW-1:0]  slp_q;

  // Semaphore store with per-entry valid bits; an invalid entry reads as zero.
  logic [SemW-1:0]     sem_mem [NUM_SEMS];
  logic [NUM_SEMS-1:0] sem_vld_q;
  logic [SemW-1:0]     sem_rd_q;
  logic                sem_rd_vld_q;

  // Thread state.
  logic [ThrW-1:0]              cur_q;
  logic [ThrW-1:0]              cand_q;
  logic [NUM_THREADS-1:0]       blocked_q;
  logic [rrts_pkg::SemIdxW-1:0] blocked_on_q [NUM_THREADS];
  logic [rrts_pkg::SleepW-1:0]  sleep_q [NUM_THREADS];
  logic [NUM_THREADS-1:0]       sleeping;

  logic [TickW-1:0] tick_q;
  logic [TickW-1:0] tick_nxt;
  logic [TickW-1:0] shift_q;
  logic [PerW-1:0]  rem0_q, rem1_q, rem0_d, rem1_d;
  logic [StepW-1:0] step_q;

  logic                   fire0_q, fire1_q, idle_q, nowait_q;
  logic signed [SemW-1:0] cnt_q;

  logic                   sem_ok;
  logic [SemAW-1:0]       sem_addr;
  logic signed [SemW-1:0] sem_cur, sem_dec, sem_inc, sem_new;
  logic                   sem_wr, blk, wake_srch, wake_mode;
  logic [ThrW-1:0]        nxt;
  logic                   ready, waiter, srch_hit, step_last;

  always_comb begin
    for (int i = 0; i < NUM_THREADS; i++) begin
      sleeping[i] = (sleep_q[i] != '0);
    end
  end

  assign sem_ok   = (int'(idx_q) < NUM_SEMS);
  assign sem_addr = SemAW'(idx_q);
  assign sem_cur  = sem_rd_vld_q ? sem_rd_q : '0;
  assign sem_dec  = (sem_cur == rrts_pkg::SemMin) ? sem_cur : sem_cur - 16'sd1;
  assign sem_inc  = (sem_cur == rrts_pkg::SemMax) ? sem_cur : sem_cur + 16'sd1;

  always_comb begin
    case (req_q)
      rrts_pkg::REQ_WAIT:   sem_new = sem_dec;
      rrts_pkg::REQ_SIGNAL: sem_new = sem_inc;
      rrts_pkg::REQ_INIT:   sem_new = init_q;
      default:              sem_new = sem_cur;
    endcase
  end

  assign sem_wr = sem_ok && (req_q == rrts_pkg::REQ_WAIT || req_q == rrts_pkg::REQ_SIGNAL ||
                             req_q == rrts_pkg::REQ_INIT);
  assign blk       = (req_q == rrts_pkg::REQ_WAIT) && sem_ok && (sem_dec < 16'sd0);
  assign wake_srch = (req_q == rrts_pkg::REQ_SIGNAL) && sem_ok && (sem_inc <= 16'sd0);
  assign wake_mode = (req_q == rrts_pkg::REQ_SIGNAL);

  assign nxt      = (cand_q == LastThr) ? '0 : cand_q + ThrW'(1);
  assign ready    = !blocked_q[nxt] && !sleeping[nxt];
  assign waiter   = blocked_q[nxt] && (blocked_on_q[nxt] == idx_q);
  assign srch_hit = wake_mode ? waiter : ready;

  assign step_last = (req_q == rrts_pkg::REQ_TICK) ? (step_q == StepW'(TickW - 1))
                                                   : (step_q == StepW'(NUM_THREADS - 1));

  assign tick_nxt = (tick_q == LastTick) ? '0 : tick_q + TickW'(1);
  assign rem0_d   = rem_step(rem0_q, shift_q[TickW-1], event0_period_i);
  assign rem1_d   = rem_step(rem1_q, shift_q[TickW-1], event1_period_i);

  assign sts_o.is_tick   = (req_q == rrts_pkg::REQ_TICK);
  assign sts_o.need_srch = (req_q == rrts_pkg::REQ_SLICE) || (req_q == rrts_pkg::REQ_SLEEP) ||
                           blk || wake_srch;
  assign sts_o.step_last = step_last;
  assign sts_o.srch_hit  = srch_hit;

  // Semaphore store: read at the address of the incoming item, written in execution.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sem_rd_q <= sem_mem[SemAW'(sem_index_i)];
    end
    if (cmd_i.exec && sem_wr) begin
      sem_mem[sem_addr] <= sem_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      cur_q     <= '0;
      cand_q    <= '0;
      step_q    <= '0;
      blocked_q <= '0;
      sem_vld_q <= '0;
      for (int i = 0; i < NUM_THREADS; i++) begin
        blocked_on_q[i] <= '0;
        sleep_q[i]      <= '0;
      end
    end else begin
      if (cmd_i.exec) begin
        cand_q <= cur_q;
        step_q <= '0;
        if (req_q == rrts_pkg::REQ_TICK) begin
          tick_q <= tick_nxt;
        end
        if (blk) begin
          blocked_q[cur_q]    <= 1'b1;
          blocked_on_q[cur_q] <= idx_q;
        end
        if (sem_wr) begin
          sem_vld_q[sem_addr] <= 1'b1;
        end
        for (int i = 0; i < NUM_THREADS; i++) begin
          if (req_q == rrts_pkg::REQ_TICK && sleeping[i]) begin
            sleep_q[i] <= sleep_q[i] - 16'd1;
          end else if (req_q == rrts_pkg::REQ_SLEEP && cur_q == ThrW'(i)) begin
            sleep_q[i] <= slp_q;
          end
        end
      end
      if (cmd_i.div_step) begin
        step_q <= step_q + StepW'(1);
      end
      if (cmd_i.srch_step) begin
        cand_q <= nxt;
        step_q <= step_q + StepW'(1);
        if (srch_hit) begin
          if (wake_mode) begin
            blocked_q[nxt]    <= 1'b0;
            blocked_on_q[nxt] <= '0;
          end else begin
            cur_q <= nxt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q        <= req_type_i;
      idx_q        <= sem_index_i;
      init_q       <= init_value_i;
      slp_q        <= sleep_ms_i;
      sem_rd_vld_q <= sem_vld_q[SemAW'(sem_index_i)];
    end
    if (cmd_i.exec) begin
      cnt_q    <= sem_ok ? sem_new : '0;
      fire0_q  <= 1'b0;
      fire1_q  <= 1'b0;
      idle_q   <= 1'b0;
      nowait_q <= 1'b0;
      shift_q  <= tick_nxt;
      rem0_q   <= '0;
      rem1_q   <= '0;
    end
    if (cmd_i.div_step) begin
      shift_q <= shift_q << 1;
      rem0_q  <= rem0_d;
      rem1_q  <= rem1_d;
      if (step_last) begin
        fire0_q <= (event0_period_i != '0) && (rem0_d == '0);
        fire1_q <= (event1_period_i != '0) && (rem1_d == '0);
      end
    end
    if (cmd_i.srch_step && !srch_hit && step_last) begin
      if (wake_mode) begin
        nowait_q <= 1'b1;
      end else begin
        idle_q <= 1'b1;
      end
    end
  end

  assign running_thread_o = rrts_pkg::ThreadOutW'(cur_q);
  assign fire_event0_o    = fire0_q;
  assign fire_event1_o    = fire1_q;
  assign idle_flag_o      = idle_q;
  assign no_waiter_flag_o = nowait_q;
  assign sem_count_o      = cnt_q;

  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cur_q) < NUM_THREADS)
    else $error("running thread index out of range");

  a_cand_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cand_q) < NUM_THREADS)
    else $error("search candidate out of range");

  a_wake_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.srch_step && srch_hit && wake_mode |=> !blocked_q[$past(nxt)])
    else $error("woken thread still blocked");

endmodule

`default_nettype wire

[hw/rtl/round_robin_thread_scheduler.sv]
// Top level of the round-robin thread scheduler: register port, controller, datapath.
// An accepted item goes from EXEC to DONE, where its result is strobed on done_o, directly
// with no search, through DIV for a tick (one remainder bit per cycle, TickW =
// clog2(TICK_WRAP)), or through SRCH for a search (one thread a cycle).
// busy_o falls the cycle after done_o, and a new item is taken only while busy_o is low, so
// none starts before the last is through; results cannot be held off, so nothing else stalls.
// Reset clears all thread, semaphore and period state at once; no clearing pass.
`default_nettype none

module round_robin_thread_scheduler #(
  parameter int NUM_THREADS = rrts_pkg::NumThreadsDef,
  parameter int NUM_SEMS    = rrts_pkg::NumSemsDef,
  parameter int TICK_WRAP   = rrts_pkg::TickWrapDef
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [rrts_pkg::ApbAddrW-1:0]       paddr,
  input  wire [rrts_pkg::ApbDataW-1:0]       pwdata,
  output logic [rrts_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready,
  input  wire                                start_i,
  output logic                               busy_o,
  output logic                               done_o,
  input  wire [rrts_pkg::ReqW-1:0]           req_type_i,
  input  wire [rrts_pkg::SemIdxW-1:0]        sem_index_i,
  input  wire signed [rrts_pkg::SemW-1:0]    init_value_i,
  input  wire [rrts_pkg::SleepW-1:0]         sleep_ms_i,
  output logic [rrts_pkg::ThreadOutW-1:0]    running_thread_o,
  output logic                               fire_event0_o,
  output logic                               fire_event1_o,
  output logic                               idle_flag_o,
  output logic                               no_waiter_flag_o,
  output logic signed [rrts_pkg::SemW-1:0]   sem_count_o
);

  logic [rrts_pkg::PeriodW-1:0] per0_q, per1_q;
  logic                         reg_sel;
  logic                         wr_en;
  rrts_pkg::cmd_t               cmd;
  rrts_pkg::sts_t               sts;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      per0_q <= '0;
      per1_q <= '0;
    end else if (wr_en) begin
      if (reg_sel == rrts_pkg::REG_EVENT0) begin
        per0_q <= pwdata[rrts_pkg::PeriodW-1:0];
      end else begin
        per1_q <= pwdata[rrts_pkg::PeriodW-1:0];
      end
    end
  end

  assign prdata = (reg_sel == rrts_pkg::REG_EVENT1) ? rrts_pkg::ApbDataW'(per1_q)
                                                    : rrts_pkg::ApbDataW'(per0_q);

  rrts_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  rrts_dp #(
    .NUM_THREADS(NUM_THREADS),
    .NUM_SEMS   (NUM_SEMS),
    .TICK_WRAP  (TICK_WRAP)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .req_type_i      (req_type_i),
    .sem_index_i     (sem_index_i),
    .init_value_i    (init_value_i),
    .sleep_ms_i      (sleep_ms_i),
    .event0_period_i (per0_q),
    .event1_period_i (per1_q),
    .running_thread_o(running_thread_o),
    .fire_event0_o   (fire_event0_o),
    .fire_event1_o   (fire_event1_o),
    .idle_flag_o     (idle_flag_o),
    .no_waiter_flag_o(no_waiter_flag_o),
    .sem_count_o     (sem_count_o)
  );

endmodule

`default_nettype wire

[tb/round_robin_thread_scheduler_tb.sv]
// Self-checking testbench of the round-robin thread scheduler: directed table, then random requests.
module round_robin_thread_scheduler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rrts_pkg::*;

  localparam int NThr          = NumThreadsDef;
  localparam int NSem          = NumSemsDef;
  localparam int CycleLimit    = 300000;
  localparam int GapCap        = 20;
  localparam int ItemsPerPhase = 495;
  localparam int NumPhases     = 4;
  localparam int NumRows       = 27;

  // Request codes the block has no use for.
  localparam logic [ReqW-1:0] REQ_RSVD6 = 3'd6;
  localparam logic [ReqW-1:0] REQ_RSVD7 = 3'd7;

  typedef struct packed {
    logic [ThreadOutW-1:0] thr;
    logic                  ev0;
    logic                  ev1;
    logic                  idle;
    logic                  no_waiter;
    logic signed [SemW-1:0] count;
  } sched_result_t;

  typedef struct packed {
    logic [ReqW-1:0]        req;
    logic [SemIdxW-1:0]     idx;
    logic signed [SemW-1:0] init;
    logic [SleepW-1:0]      slp;
    logic                   typed;
    sched_result_t          want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   psel = 1'b0;
  logic                   penable = 1'b0;
  logic                   pwrite = 1'b0;
  logic [ApbAddrW-1:0]    paddr = '0;
  logic [ApbDataW-1:0]    pwdata = '0;
  logic [ApbDataW-1:0]    prdata;
  logic                   pready;
  logic                   start_i = 1'b0;
  logic                   busy_o;
  logic                   done_o;
  logic [ReqW-1:0]        req_type_i = '0;
  logic [SemIdxW-1:0]     sem_index_i = '0;
  logic signed [SemW-1:0] init_value_i = '0;
  logic [SleepW-1:0]      sleep_ms_i = '0;
  logic [ThreadOutW-1:0]  running_thread_o;
  logic                   fire_event0_o;
  logic                   fire_event1_o;
  logic                   idle_flag_o;
  logic                   no_waiter_flag_o;
  logic signed [SemW-1:0] sem_count_o;

  // Travels with each item: a typed-in expectation replaces the prediction.
  logic          use_table_result = 1'b0;
  sched_result_t table_result = '0;

  // Mirror of the scheduler state, as of the last accepted item.
  logic [ThreadOutW-1:0]  run_thr = '0;
  bit                     thr_blocked [NThr] = '{default: 1'b0};
  logic [SemIdxW-1:0]     thr_sem [NThr] = '{default: '0};
  logic [SleepW-1:0]      thr_nap [NThr] = '{default: '0};
  logic signed [SemW-1:0] sem_cnt [NSem] = '{default: '0};
  int                     tick_cnt = 0;
  logic [PeriodW-1:0]     ev0_per = '0;
  logic [PeriodW-1:0]     ev1_per = '0;

  sched_result_t pending [$];
  int            errors = 0;
  int            cycle_cnt = 0;

  round_robin_thread_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .done_o          (done_o),
    .req_type_i      (req_type_i),
    .sem_index_i     (sem_index_i),
    .init_value_i    (init_value_i),
    .sleep_ms_i      (sleep_ms_i),
    .running_thread_o(running_thread_o),
    .fire_event0_o   (fire_event0_o),
    .fire_event1_o   (fire_event1_o),
    .idle_flag_o     (idle_flag_o),
    .no_waiter_flag_o(no_waiter_flag_o),
    .sem_count_o     (sem_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Hands the processor to the first ready thread after the running one,
  // the running one itself last. Returns 1 when no thread is ready.
  function automatic bit pick_ready();
    int t;
    bit found;
    t = run_thr;
    found = 1'b0;
    for (int n = 0; n < NThr && !found; n++) begin
      t = (t + 1 >= NThr) ? 0 : t + 1;
      if (!thr_blocked[t] && thr_nap[t] == '0) begin
        run_thr = ThreadOutW'(t);
        found = 1'b1;
      end
    end
    return !found;
  endfunction

  function automatic sched_result_t apply_request(logic [ReqW-1:0] req,
                                                  logic [SemIdxW-1:0] idx,
                                                  logic signed [SemW-1:0] init,
                                                  logic [SleepW-1:0] slp);
    sched_result_t r;
    int t;
    bit in_range;
    r = '0;
    in_range = int'(idx) < NSem;
    case (req)
      REQ_TICK: begin
        tick_cnt = (tick_cnt + 1 >= TickWrapDef) ? 0 : tick_cnt + 1;
        r.ev0 = ev0_per != '0 && (tick_cnt % int'(ev0_per)) == 0;
        r.ev1 = ev1_per != '0 && (tick_cnt % int'(ev1_per)) == 0;
        for (int i = 0; i < NThr; i++) begin
          if (thr_nap[i] != '0) thr_nap[i] = thr_nap[i] - 1'b1;
        end
      end
      REQ_SLICE: begin
        r.idle = pick_ready();
      end
      REQ_SLEEP: begin
        thr_nap[run_thr] = slp;
        r.idle = pick_ready();
      end
      REQ_WAIT: begin
        if (in_range) begin
          if (sem_cnt[idx] != SemMin) sem_cnt[idx] = sem_cnt[idx] - 16'sd1;
          if (sem_cnt[idx] < 0) begin
            thr_blocked[run_thr] = 1'b1;
            thr_sem[run_thr] = idx;
            r.idle = pick_ready();
          end
        end
      end
      REQ_SIGNAL: begin
        if (in_range) begin
          if (sem_cnt[idx] != SemMax) sem_cnt[idx] = sem_cnt[idx] + 16'sd1;
          if (sem_cnt[idx] <= 0) begin
            // Wake the first waiter after the running thread; none found raises the flag.
            r.no_waiter = 1'b1;
            t = run_thr;
            for (int n = 0; n < NThr; n++) begin
              t = (t + 1 >= NThr) ? 0 : t + 1;
              if (r.no_waiter && thr_blocked[t] && thr_sem[t] == idx) begin
                thr_blocked[t] = 1'b0;
                thr_sem[t] = '0;
                r.no_waiter = 1'b0;
              end
            end
          end
        end
      end
      REQ_INIT: begin
        if (in_range) sem_cnt[idx] = init;
      end
      default: begin
      end
    endcase
    r.thr = run_thr;
    r.count = in_range ? sem_cnt[idx] : '0;
    return r;
  endfunction

  task automatic check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Results are matched before the item accepted at the same edge is predicted.
  always @(posedge clk_i) begin : scoreboard
    sched_result_t got;
    sched_result_t want;
    sched_result_t pred;
    if (rst_ni) begin
      if (done_o) begin
        got.thr = running_thread_o;
        got.ev0 = fire_event0_o;
        got.ev1 = fire_event1_o;
        got.idle = idle_flag_o;
        got.no_waiter = no_waiter_flag_o;
        got.count = sem_count_o;
        if (pending.size() == 0) begin
          $display("%0t: unexpected result: expected none, got thread %0d count %0d",
                   $time, got.thr, got.count);
          errors++;
        end else begin
          want = pending.pop_front();
          check_field("running_thread", want.thr, got.thr);
          check_field("fire_event0", want.ev0, got.ev0);
          check_field("fire_event1", want.ev1, got.ev1);
          check_field("idle_flag", want.idle, got.idle);
          check_field("no_waiter_flag", want.no_waiter, got.no_waiter);
          check_field("sem_count", want.count, got.count);
        end
      end
      if (start_i && !busy_o) begin
        pred = apply_request(req_type_i, sem_index_i, init_value_i, sleep_ms_i);
        pending.push_back(use_table_result ? table_result : pred);
      end
    end
  end

  task automatic apb_access(bit wr, logic [ApbAddrW-1:0] addr, logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= addr;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_period(logic sel, logic [PeriodW-1:0] val);
    logic [ApbDataW-1:0] rd;
    apb_access(1'b1, {sel, 2'b00}, ApbDataW'(val), rd);
    if (sel == REG_EVENT0) ev0_per = val;
    else ev1_per = val;
    apb_access(1'b0, {sel, 2'b00}, '0, rd);
    if (rd != ApbDataW'(val)) begin
      $display("%0t: period register %0d readback: expected %0d, got %0d",
               $time, sel, val, rd);
      errors++;
    end
  endtask

  // Returns at the edge that accepts the item; start stays high for the caller.
  task automatic issue_request(logic [ReqW-1:0] req, logic [SemIdxW-1:0] idx,
                               logic signed [SemW-1:0] init, logic [SleepW-1:0] slp,
                               logic typed, sched_result_t want);
    start_i <= 1'b1;
    req_type_i <= req;
    sem_index_i <= idx;
    init_value_i <= init;
    sleep_ms_i <= slp;
    use_table_result <= typed;
    table_result <= want;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic sender_gap(int pct);
    int n;
    n = 0;
    while (n < GapCap && int'($urandom_range(99)) < pct) begin
      start_i <= 1'b0;
      req_type_i <= ReqW'($urandom);
      sem_index_i <= SemIdxW'($urandom);
      @(posedge clk_i);
      n++;
    end
  endtask

  task automatic wait_all_results();
    start_i <= 1'b0;
    do @(negedge clk_i); while (pending.size() != 0 || busy_o);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    dir_row_t dir_rows [NumRows];
    int per0_sel [NumPhases];
    int per1_sel [NumPhases];
    int gap_pct [NumPhases];
    int r;
    bit tail;
    logic [ReqW-1:0] req;
    logic [SemIdxW-1:0] idx;
    logic signed [SemW-1:0] init;
    logic [SleepW-1:0] slp;

    per0_sel = '{5, 127, 0, 1};
    per1_sel = '{10, 100, 0, 99};
    gap_pct = '{13, 59, 0, 0};

    // Expectations are typed in for the opening rows, with event periods one and two.
    dir_rows = '{
      '{REQ_RSVD7, 3'd7, SemMin, 16'hffff, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sd0}},
      '{REQ_RSVD6, 3'd0, 16'sd0, 16'd0, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, 16'sd0}},
      '{REQ_TICK, 3'd0, 16'sd0, 16'd0, 1'b1, '{3'd0, 1'b1, 1'b0, 1'b0, 1'b0, 16'sd0}},
      '{REQ_TICK, 3'd0, 16'sd0, 16'd0, 1'b1, '{3'd0, 1'b1, 1'b1, 1'b0, 1'b0, 16'sd0}},
      '{REQ_INIT, 3'd7, SemMax, 16'd0, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, SemMax}},
      '{REQ_SIGNAL, 3'd7, 16'sd0, 16'd0, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, SemMax}},
      '{REQ_INIT, 3'd6, SemMin, 16'd0, 1'b1, '{3'd0, 1'b0, 1'b0, 1'b0, 1'b0, SemMin}},
      '{REQ_WAIT, 3'd6, 16'sd0, 16'd0, 1'b1, '{3'd1, 1'b0, 1'b0, 1'b0, 1'b0, SemMin}},
      '{REQ_SIGNAL, 3'd6, 16'sd0, 16'd0, 1'b1, '{3'd1, 1'b0, 1'b0, 1'b0, 1'b0, -16'sd32767}},
      '{REQ_SIGNAL, 3'd6, 16'sd0, 16'd0, 1'b1, '{3'd1, 1'b0, 1'b0, 1'b0, 1'b1, -16'sd32766}},
      '{REQ_SLICE, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_SLEEP, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_SLEEP, 3'd0, 16'sd0, 16'hffff, 1'b0, '0},
      '{REQ_INIT, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_WAIT, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_WAIT, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_WAIT, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_SLEEP, 3'd0, 16'sd0, 16'd2, 1'b0, '0},
      '{REQ_SLEEP, 3'd0, 16'sd0, 16'd1, 1'b0, '0},
      '{REQ_SLICE, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_TICK, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_SLICE, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_SIGNAL, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_SIGNAL, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_SIGNAL, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_SIGNAL, 3'd0, 16'sd0, 16'd0, 1'b0, '0},
      '{REQ_WAIT, 3'd7, 16'sd0, 16'd0, 1'b0, '0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_period(REG_EVENT0, 7'd1);
    set_period(REG_EVENT1, 7'd2);
    for (int i = 0; i < NumRows; i++) begin
      issue_request(dir_rows[i].req, dir_rows[i].idx, dir_rows[i].init, dir_rows[i].slp,
                    dir_rows[i].typed, dir_rows[i].want);
    end
    wait_all_results();

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_period(REG_EVENT0, PeriodW'(per0_sel[ph]));
      set_period(REG_EVENT1, PeriodW'(per1_sel[ph]));
      for (int n = 0; n < ItemsPerPhase; n++) begin
        r = $urandom_range(99);
        if (r < 28) req = REQ_TICK;
        else if (r < 42) req = REQ_SLICE;
        else if (r < 54) req = REQ_SLEEP;
        else if (r < 70) req = REQ_WAIT;
        else if (r < 88) req = REQ_SIGNAL;
        else if (r < 95) req = REQ_INIT;
        else req = $urandom_range(1) ? REQ_RSVD7 : REQ_RSVD6;

        // Most traffic stays on a few semaphores so that waits and signals meet.
        idx = ($urandom_range(3) != 0) ? SemIdxW'($urandom_range(2)) : SemIdxW'($urandom);

        r = $urandom_range(99);
        if (req != REQ_INIT || r >= 85) init = SemW'($urandom);
        else if (r < 70) init = SemW'($urandom_range(6)) - 16'sd3;
        else init = $urandom_range(1) ? SemMax : SemMin;

        // Long sleeps would park a thread for the rest of the run, so they
        // only come near its end.
        tail = (ph == NumPhases - 1) && (n >= ItemsPerPhase - 40);
        if (req != REQ_SLEEP || (tail && $urandom_range(3) == 0)) slp = SleepW'($urandom);
        else slp = SleepW'($urandom_range(6));

        issue_request(req, idx, init, slp, 1'b0, '0);
        if ($urandom_range(99) == 0) wait_all_results();
        else sender_gap(gap_pct[ph]);
      end
      wait_all_results();
    end

    repeat (12) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
